>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)

`define ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> rtl/oale_pkg.sv
// ---------------------------------------------------------------------------
// Ordered array list package
// Sizes, operation and status codes, the entry type and the signed key compare of the list engine.
// ---------------------------------------------------------------------------
package oale_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 7;
  localparam int POS_W    = 7;
  localparam int FIDX_W   = 6;
  localparam int OP_W     = 3;
  localparam int ST_W     = 3;
  localparam int DATA_W   = 32;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR   = 3'd0,
    OP_INSERT  = 3'd1,
    OP_REMOVE  = 3'd2,
    OP_READ    = 3'd3,
    OP_FIND    = 3'd4,
    OP_SORT_UP = 3'd5,
    OP_SORT_DN = 3'd6
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_BADIDX = 3'd3,
    ST_NOKEY  = 3'd4
  } status_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
  } entry_t;

  function automatic logic key_gt(logic signed [DATA_W-1:0] a,
                                  logic signed [DATA_W-1:0] b);
    return a > b;
  endfunction

endpackage

>>> rtl/ordered_array_list_engine_top.sv
// ---------------------------------------------------------------------------
// Ordered array list engine
// Bounded positional key/value list with clear, insert, remove, read, find and sort.
// ---------------------------------------------------------------------------
// The request channel (req_valid, req_stall) carries op, pos, key and value.
// The response channel (rsp_valid, rsp_stall) carries one result for every
// request: status, out_key, out_value, found_index, entry_count, is_empty
// and is_full. Entries live in a single 64-deep memory with one write port
// and one registered read port; find compares keys for equality, sort with key_gt.
// The engine takes one request at a time and holds req_stall high while it
// works. Each memory access is a read registered in S_READ and then used
// in S_STEP; clear ends in S_START, the other operations make one access
// per entry read, visited or shifted, and insert and each sort pass end in
// S_PUT. A finished result sits in the output register while the
// next request is accepted; a new result waits until the receiver takes the
// previous one, so a stalled receiver simply holds the engine at its end.
// Reset empties the list at once; memory contents need no clearing since
// only positions below the count are ever read.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ordered_array_list_engine_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [oale_pkg::OP_W-1:0]     op,
  input  logic [oale_pkg::POS_W-1:0]    pos,
  input  logic signed [oale_pkg::DATA_W-1:0] key,
  input  logic signed [oale_pkg::DATA_W-1:0] value,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [oale_pkg::ST_W-1:0]     status,
  output logic signed [oale_pkg::DATA_W-1:0] out_key,
  output logic signed [oale_pkg::DATA_W-1:0] out_value,
  output logic [oale_pkg::FIDX_W-1:0]   found_index,
  output logic [oale_pkg::CNT_W-1:0]    entry_count,
  output logic                          is_empty,
  output logic                          is_full
);
  import oale_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_START = 6'b000010,
    S_READ  = 6'b000100,
    S_STEP  = 6'b001000,
    S_PUT   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;

  entry_t mem [CAPACITY];
  entry_t rd_data;

  op_t                      op_r;
  logic [POS_W-1:0]         pos_r;
  logic signed [DATA_W-1:0] key_r;
  logic signed [DATA_W-1:0] value_r;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         idx;
  logic [CNT_W-1:0]         lim;
  logic                     first;
  entry_t                   cur;

  status_t                  res_status;
  logic signed [DATA_W-1:0] res_key;
  logic signed [DATA_W-1:0] res_value;
  logic [FIDX_W-1:0]        res_fidx;

  logic                     is_sort;
  logic                     swap;
  logic [CNT_W-1:0]         idx_inc;
  logic [CNT_W-1:0]         idx_inc2;
  logic [CNT_W-1:0]         idx_dec;
  logic [CNT_W-1:0]         rd_idx;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;
  entry_t                   wr_data;

  assign is_sort  = (op_r == OP_SORT_UP) || (op_r == OP_SORT_DN);
  assign idx_inc  = idx + CNT_W'(1);
  assign idx_inc2 = idx + CNT_W'(2);
  assign idx_dec  = idx - CNT_W'(1);
  assign swap     = (op_r == OP_SORT_DN) ? key_gt(rd_data.key, cur.key)
                                         : key_gt(cur.key, rd_data.key);
  assign req_stall = (state != S_IDLE);

  always_comb begin
    if (op_r == OP_INSERT) begin
      rd_idx = idx_dec;
    end else if ((op_r == OP_REMOVE || is_sort) && !first) begin
      rd_idx = idx_inc;
    end else begin
      rd_idx = idx;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx[IDX_W-1:0];
    wr_data = rd_data;
    if (state == S_PUT) begin
      wr_en = 1'b1;
      if (op_r == OP_INSERT) begin
        wr_addr = pos_r[IDX_W-1:0];
        wr_data = '{key: key_r, value: value_r};
      end else begin
        wr_data = cur;
      end
    end else if (state == S_STEP) begin
      wr_en = (op_r == OP_INSERT) || ((op_r == OP_REMOVE || is_sort) && !first);
      if (is_sort) begin
        wr_data = swap ? rd_data : cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op_r    <= op_t'(op);
            pos_r   <= pos;
            key_r   <= key;
            value_r <= value;
            state   <= S_START;
          end
        end
        S_START: begin
          res_status <= ST_OK;
          res_key    <= '0;
          res_value  <= '0;
          res_fidx   <= '0;
          first      <= 1'b1;
          idx        <= '0;
          state      <= S_DONE;
          unique case (op_r)
            OP_CLEAR: begin
              count <= '0;
            end
            OP_INSERT: begin
              if (count == CAP_CNT) begin
                res_status <= ST_FULL;
              end else if (pos_r > count) begin
                res_status <= ST_BADIDX;
              end else begin
                idx   <= count;
                state <= (count == pos_r) ? S_PUT : S_READ;
              end
            end
            OP_REMOVE: begin
              if (count == '0) begin
                res_status <= ST_EMPTY;
              end else if (pos_r >= count) begin
                res_status <= ST_BADIDX;
              end else begin
                idx   <= pos_r;
                state <= S_READ;
              end
            end
            OP_READ: begin
              if (pos_r >= count) begin
                res_status <= ST_BADIDX;
              end else begin
                idx   <= pos_r;
                state <= S_READ;
              end
            end
            OP_FIND: begin
              res_status <= ST_NOKEY;
              if (count != '0) begin
                state <= S_READ;
              end
            end
            OP_SORT_UP, OP_SORT_DN: begin
              lim <= count - CNT_W'(1);
              if (count > CNT_W'(1)) begin
                state <= S_READ;
              end
            end
            default: begin
            end
          endcase
        end
        S_READ: begin
          state <= S_STEP;
        end
        S_STEP: begin
          state <= S_DONE;
          unique case (op_r)
            OP_INSERT: begin
              idx   <= idx_dec;
              state <= (idx_dec == pos_r) ? S_PUT : S_READ;
            end
            OP_REMOVE: begin
              if (first) begin
                first     <= 1'b0;
                res_key   <= rd_data.key;
                res_value <= rd_data.value;
                if (idx_inc == count) begin
                  count <= count - CNT_W'(1);
                end else begin
                  state <= S_READ;
                end
              end else begin
                idx <= idx_inc;
                if (idx_inc2 == count) begin
                  count <= count - CNT_W'(1);
                end else begin
                  state <= S_READ;
                end
              end
            end
            OP_READ: begin
              res_key   <= rd_data.key;
              res_value <= rd_data.value;
            end
            OP_FIND: begin
              if (rd_data.key == key_r) begin
                res_status <= ST_OK;
                res_key    <= rd_data.key;
                res_value  <= rd_data.value;
                res_fidx   <= idx[FIDX_W-1:0];
              end else begin
                idx <= idx_inc;
                if (idx_inc != count) begin
                  state <= S_READ;
                end
              end
            end
            OP_SORT_UP, OP_SORT_DN: begin
              if (first) begin
                first <= 1'b0;
                cur   <= rd_data;
                state <= S_READ;
              end else begin
                if (!swap) begin
                  cur <= rd_data;
                end
                idx   <= idx_inc;
                state <= (idx_inc == lim) ? S_PUT : S_READ;
              end
            end
            default: begin
            end
          endcase
        end
        S_PUT: begin
          state <= S_DONE;
          if (op_r == OP_INSERT) begin
            count <= count + CNT_W'(1);
          end else if (lim != CNT_W'(1)) begin
            lim   <= lim - CNT_W'(1);
            idx   <= '0;
            first <= 1'b1;
            state <= S_READ;
          end
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid   <= 1'b1;
            status      <= res_status;
            out_key     <= res_key;
            out_value   <= res_value;
            found_index <= res_fidx;
            entry_count <= count;
            is_empty    <= (count == '0);
            is_full     <= (count == CAP_CNT);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_CLK(a_count_bound, count <= CAP_CNT, "entry count above capacity")
  `ASSERT_CLK(a_rsp_from_done, $rose(rsp_valid) |-> $past(state == S_DONE), "response without completion")
  `ASSERT_CLK(a_accept_start, (req_valid && !req_stall) |=> (state == S_START), "accepted request not started")
  `ASSERT_CLK(a_count_step, (count != $past(count)) |-> (count == $past(count) + CNT_W'(1) || count == $past(count) - CNT_W'(1) || count == '0), "count changed by more than one")

endmodule
